@@ rtl/u8sb_pkg.sv @@
// shared types and constants for the utf8 substring bounds block
package u8sb_pkg;

   localparam int MAX_BYTES_DEF = 4096;
   localparam int FIELD_W       = 33;
   localparam int ARITH_W       = 35;
   localparam int OUT_W         = 13;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAN,
      ST_INDEX,
      ST_READ,
      ST_FINISH
   } u8sb_state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
      logic               overflow;
   } u8sb_args_type;

   typedef struct packed {
      logic [OUT_W-1:0] slice_start;
      logic [OUT_W-1:0] slice_bytes;
      logic             slice_empty;
      logic             range_error;
   } u8sb_result_type;

endpackage

@@ rtl/utf8_substring_bounds_top.sv @@
// top level: byte intake, lead position ram and the bounds sequencer
// an item without a last mark is taken when start is high and busy is low; busy stays low after it
// an item with a last mark raises busy while the sequencer runs
// (two arithmetic steps, one two-port ram read, one compare); rsp_valid is registered
// from the compare step and pulses as busy drops, when the next item may already be taken
// synchronous reset clears counts and held values; the ram is not cleared
module utf8_substring_bounds_top
   import u8sb_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [7:0]          req_data_byte,
   input  logic                req_byte_present,
   input  logic                req_first_byte,
   input  logic                req_last_byte,
   input  logic signed [FIELD_W-1:0] req_start_offset,
   input  logic signed [FIELD_W-1:0] req_take_length,
   output logic                rsp_valid,
   output logic [OUT_W-1:0]    rsp_slice_start,
   output logic [OUT_W-1:0]    rsp_slice_bytes,
   output logic                rsp_slice_empty,
   output logic                rsp_range_error
);

   localparam int CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int ADDR_W = $clog2(MAX_BYTES);

   logic [CNT_W-1:0]   lead_count_ff, lead_count_in, byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]   base_lead, base_bytes;
   logic [FIELD_W-1:0] offset_ff, offset_in, length_ff, length_in;
   logic               overflow_ff, overflow_in, base_ovf;
   logic               accept, full, take, wr_en;
   logic [ADDR_W-1:0]  rd_addr_s, rd_addr_e, rd_data_s, rd_data_e;
   u8sb_args_type      args;
   u8sb_result_type    rsp;

   assign accept     = start && !busy;
   assign base_lead  = req_first_byte ? '0 : lead_count_ff;
   assign base_bytes = req_first_byte ? '0 : byte_count_ff;
   assign base_ovf   = req_first_byte ? 1'b0 : overflow_ff;
   assign full       = base_bytes == CNT_W'(MAX_BYTES);
   assign take       = accept && req_byte_present && !full;
   // continuation bytes carry 10 in their top bits
   assign wr_en      = take && (req_data_byte[7:6] != 2'b10);

   always_comb begin
      lead_count_in = lead_count_ff;
      byte_count_in = byte_count_ff;
      overflow_in   = overflow_ff;
      offset_in     = offset_ff;
      length_in     = length_ff;
      if (accept) begin
         lead_count_in = base_lead + CNT_W'(wr_en);
         byte_count_in = base_bytes + CNT_W'(take);
         overflow_in   = base_ovf || (req_byte_present && full);
         if (req_first_byte) begin
            offset_in = req_start_offset;
            length_in = req_take_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_count_ff <= '0;
         byte_count_ff <= '0;
         overflow_ff   <= 1'b0;
         offset_ff     <= '0;
         length_ff     <= '0;
      end else begin
         lead_count_ff <= lead_count_in;
         byte_count_ff <= byte_count_in;
         overflow_ff   <= overflow_in;
         offset_ff     <= offset_in;
         length_ff     <= length_in;
      end
   end

   assign args.offset   = offset_ff;
   assign args.length   = length_ff;
   assign args.overflow = overflow_ff;

   u8sb_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MAX_BYTES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (base_lead[ADDR_W-1:0]),
      .wr_data   (ADDR_W'(base_bytes)),
      .rd_addr_a (rd_addr_s),
      .rd_data_a (rd_data_s),
      .rd_addr_b (rd_addr_e),
      .rd_data_b (rd_data_e)
   );

   u8sb_bounds #(
      .MAX_BYTES (MAX_BYTES),
      .CNT_W     (CNT_W),
      .ADDR_W    (ADDR_W)
   ) u_bounds (
      .clock      (clock),
      .reset      (reset),
      .go         (accept && req_last_byte),
      .args       (args),
      .lead_count (lead_count_ff),
      .byte_count (byte_count_ff),
      .busy       (busy),
      .rd_addr_s  (rd_addr_s),
      .rd_addr_e  (rd_addr_e),
      .rd_data_s  (rd_data_s),
      .rd_data_e  (rd_data_e),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_slice_start = rsp.slice_start;
   assign rsp_slice_bytes = rsp.slice_bytes;
   assign rsp_slice_empty = rsp.slice_empty;
   assign rsp_range_error = rsp.range_error;

endmodule

@@ rtl/u8sb_ram.sv @@
// generic ram, one write port and two registered read ports
module u8sb_ram
   import u8sb_pkg::*;
#(
   parameter int WIDTH = 12,
   parameter int DEPTH = MAX_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/u8sb_bounds.sv @@
// sequencer that turns held offset, length and counts into byte bounds
module u8sb_bounds
   import u8sb_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF,
   parameter int CNT_W     = $clog2(MAX_BYTES + 1),
   parameter int ADDR_W    = $clog2(MAX_BYTES)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  u8sb_args_type   args,
   input  logic [CNT_W-1:0] lead_count,
   input  logic [CNT_W-1:0] byte_count,
   output logic            busy,
   output logic [ADDR_W-1:0] rd_addr_s,
   output logic [ADDR_W-1:0] rd_addr_e,
   input  logic [ADDR_W-1:0] rd_data_s,
   input  logic [ADDR_W-1:0] rd_data_e,
   output logic            rsp_valid,
   output u8sb_result_type rsp
);

   u8sb_state_type state_ff, state_in;

   logic signed [ARITH_W-1:0] off, len, n_s, n_p1, o_v, m_v, t_v;
   logic signed [ARITH_W-1:0] s_in, e_in, s_ff, e_ff;
   logic signed [ARITH_W-1:0] ks_in, ke_in, ks_ff, ke_ff;
   logic                      pos_ff, zero_ff, empty_in, empty_ff;
   logic                      use_s_in, use_e_in, use_s_ff, use_e_ff;
   logic [CNT_W-1:0]          sp, ep;
   u8sb_result_type           rsp_in, rsp_ff;
   logic                      valid_in, valid_ff;

   assign off  = ARITH_W'($signed(args.offset));
   assign len  = ARITH_W'($signed(args.length));
   assign n_s  = $signed({{(ARITH_W - CNT_W){1'b0}}, lead_count});
   assign n_p1 = n_s + ARITH_W'(1);
   assign o_v  = off - ARITH_W'(1);
   assign m_v  = ARITH_W'(1) - off;
   assign t_v  = o_v + len;

   // start and end codepoint numbers
   always_comb begin
      if (!off[ARITH_W-1]) begin
         if (len[ARITH_W-1]) begin
            s_in = t_v[ARITH_W-1] ? '0 : t_v;
            e_in = o_v;
         end else begin
            s_in = o_v[ARITH_W-1] ? '0 : o_v;
            e_in = t_v;
         end
      end else begin
         if (len[ARITH_W-1]) begin
            s_in = m_v - len;
            e_in = m_v;
         end else begin
            s_in = m_v;
            e_in = m_v - len;
         end
      end
   end

   // boundary indices and the early empty decision
   always_comb begin
      if (pos_ff) begin
         empty_in = (s_ff >= n_s) || (e_ff <= 0) || (e_ff <= s_ff);
         ks_in    = s_ff;
         ke_in    = (e_ff < n_s) ? e_ff : n_s;
      end else begin
         empty_in = e_ff > n_s;
         ks_in    = (s_ff <= n_p1) ? (n_p1 - s_ff) : '0;
         ke_in    = (e_ff <= 0) ? n_s : (n_p1 - e_ff);
      end
      empty_in = empty_in || zero_ff;
   end

   // index past the last lead byte reads as the string end
   assign use_s_in  = !ks_ff[ARITH_W-1] && (ks_ff < n_s);
   assign use_e_in  = !ke_ff[ARITH_W-1] && (ke_ff < n_s);
   assign rd_addr_s = ks_ff[ADDR_W-1:0];
   assign rd_addr_e = ke_ff[ADDR_W-1:0];

   assign sp = use_s_ff ? CNT_W'(rd_data_s) : byte_count;
   assign ep = use_e_ff ? CNT_W'(rd_data_e) : byte_count;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN:  state_in = ST_INDEX;
         ST_INDEX: state_in = ST_READ;
         ST_READ:  state_in = ST_FINISH;
         ST_FINISH: begin
            state_in = ST_IDLE;
            valid_in = 1'b1;
            rsp_in   = '0;
            if (args.overflow) begin
               rsp_in.range_error = 1'b1;
            end else if (empty_ff || !(ep > sp)) begin
               rsp_in.slice_empty = 1'b1;
            end else begin
               rsp_in.slice_start = OUT_W'(sp);
               rsp_in.slice_bytes = OUT_W'(ep - sp);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_SPAN) begin
         s_ff    <= s_in;
         e_ff    <= e_in;
         pos_ff  <= !off[ARITH_W-1];
         zero_ff <= len == 0;
      end
      if (state_ff == ST_INDEX) begin
         ks_ff    <= ks_in;
         ke_ff    <= ke_in;
         empty_ff <= empty_in;
      end
      if (state_ff == ST_READ) begin
         use_s_ff <= use_s_in;
         use_e_ff <= use_e_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ bench/u8sb_bounds_checker.sv @@
// checker for the utf8 substring bounds block: predicts each slice and compares rsp strobes
`timescale 1ns / 100ps
module u8sb_bounds_checker
   import u8sb_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_byte_present,
   input  logic                      req_first_byte,
   input  logic                      req_last_byte,
   input  logic signed [FIELD_W-1:0] req_start_offset,
   input  logic signed [FIELD_W-1:0] req_take_length,
   input  logic                      rsp_valid,
   input  logic [OUT_W-1:0]          rsp_slice_start,
   input  logic [OUT_W-1:0]          rsp_slice_bytes,
   input  logic                      rsp_slice_empty,
   input  logic                      rsp_range_error,
   output int                        errors,
   output int                        outstanding
);

   logic [OUT_W-1:0] lead_pos [MAX_BYTES];
   int               lead_cnt = 0;
   int               byte_cnt = 0;
   longint           held_off = 0;
   longint           held_len = 0;
   bit               oversize = 1'b0;
   u8sb_result_type  slice_q[$];
   int               fail_count = 0;
   int               queued = 0;

   assign errors      = fail_count;
   assign outstanding = queued;

   // byte position of codepoint k, or the end of the string past the last lead
   function automatic int lead_at(longint k);
      if (k >= 0 && k < lead_cnt && k < MAX_BYTES) return int'(lead_pos[k]);
      return byte_cnt;
   endfunction

   // sql substring rules over the held offset and length
   function automatic bit find_span(output int sp, output int ep);
      longint n, off, len, s, e, m, ks, ke;
      n   = longint'(lead_cnt);
      off = held_off;
      len = held_len;
      sp  = 0;
      ep  = 0;
      if (len == 0) return 1'b0;
      if (off >= 0) begin
         m = off - 1;
         if (len < 0) begin
            s = (m + len < 0) ? 0 : m + len;
            e = m;
         end else begin
            s = (m < 0) ? 0 : m;
            e = m + len;
         end
         if (s >= n || e <= 0 || e <= s) return 1'b0;
         sp = lead_at(s);
         ep = (e < n) ? lead_at(e) : byte_cnt;
      end else begin
         // negative offset counts back from the end
         m = 1 - off;
         if (len < 0) begin
            s = m - len;
            e = m;
         end else begin
            s = m;
            e = m - len;
         end
         if (e > n) return 1'b0;
         ks = (s <= n + 1) ? n + 1 - s : 0;
         ke = (e <= 0) ? n : n + 1 - e;
         sp = lead_at(ks);
         ep = lead_at(ke);
      end
      return ep > sp;
   endfunction

   always @(posedge clock) begin
      u8sb_result_type got, want;
      int sp, ep;
      if (reset) begin
         lead_cnt = 0;
         byte_cnt = 0;
         held_off = 0;
         held_len = 0;
         oversize = 1'b0;
         slice_q.delete();
      end else begin
         if (rsp_valid) begin
            got = '{rsp_slice_start, rsp_slice_bytes, rsp_slice_empty, rsp_range_error};
            if (slice_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: start=%0d bytes=%0d empty=%0b err=%0b",
                           got.slice_start, got.slice_bytes, got.slice_empty,
                           got.range_error);
            end else begin
               want = slice_q.pop_front();
               if (got.slice_start !== want.slice_start ||
                   got.slice_bytes !== want.slice_bytes ||
                   got.slice_empty !== want.slice_empty ||
                   got.range_error !== want.range_error) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected start=%0d bytes=%0d empty=%0b err=%0b, %s",
                              want.slice_start, want.slice_bytes, want.slice_empty,
                              want.range_error,
                              $sformatf("got start=%0d bytes=%0d empty=%0b err=%0b",
                                        got.slice_start, got.slice_bytes,
                                        got.slice_empty, got.range_error));
               end
            end
         end

         if (start && !busy) begin
            if (req_first_byte) begin
               lead_cnt = 0;
               byte_cnt = 0;
               oversize = 1'b0;
               held_off = longint'(req_start_offset);
               held_len = longint'(req_take_length);
            end
            if (req_byte_present) begin
               if (byte_cnt >= MAX_BYTES) begin
                  oversize = 1'b1;
               end else begin
                  if (req_data_byte[7:6] != 2'b10 && lead_cnt < MAX_BYTES) begin
                     lead_pos[lead_cnt] = OUT_W'(byte_cnt);
                     lead_cnt++;
                  end
                  byte_cnt++;
               end
            end
            if (req_last_byte) begin
               want = '0;
               if (oversize) begin
                  want.range_error = 1'b1;
               end else if (find_span(sp, ep)) begin
                  want.slice_start = OUT_W'(sp);
                  want.slice_bytes = OUT_W'(ep - sp);
               end else begin
                  want.slice_empty = 1'b1;
               end
               slice_q.push_back(want);
            end
         end
      end
      queued <= slice_q.size();
   end

endmodule

@@ bench/tb_top.sv @@
// testbench top: drives utf8 strings into the substring bounds block and gives the verdict
`timescale 1ns / 100ps
module tb_top
   import u8sb_pkg::*;
();

   localparam int LIMIT = 1_000_000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic [7:0]                req_data_byte = '0;
   logic                      req_byte_present = 1'b0;
   logic                      req_first_byte = 1'b0;
   logic                      req_last_byte = 1'b0;
   logic signed [FIELD_W-1:0] req_start_offset = '0;
   logic signed [FIELD_W-1:0] req_take_length = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic [OUT_W-1:0]          rsp_slice_start;
   logic [OUT_W-1:0]          rsp_slice_bytes;
   logic                      rsp_slice_empty;
   logic                      rsp_range_error;
   int                        errors;
   int                        outstanding;
   int                        cycles = 0;
   int                        sent = 0;
   bit                        burst = 1'b0;
   logic [7:0]                text[$];

   utf8_substring_bounds_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_start_offset (req_start_offset),
      .req_take_length  (req_take_length),
      .rsp_valid        (rsp_valid),
      .rsp_slice_start  (rsp_slice_start),
      .rsp_slice_bytes  (rsp_slice_bytes),
      .rsp_slice_empty  (rsp_slice_empty),
      .rsp_range_error  (rsp_range_error)
   );

   u8sb_bounds_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_start_offset (req_start_offset),
      .req_take_length  (req_take_length),
      .rsp_valid        (rsp_valid),
      .rsp_slice_start  (rsp_slice_start),
      .rsp_slice_bytes  (rsp_slice_bytes),
      .rsp_slice_empty  (rsp_slice_empty),
      .rsp_range_error  (rsp_range_error),
      .errors           (errors),
      .outstanding      (outstanding)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [FIELD_W-1:0] any33();
      logic signed [FIELD_W-1:0] v;
      v[32]   = 1'($urandom_range(0, 1));
      v[31:0] = $urandom();
      return v;
   endfunction

   // offsets and lengths: mostly within n + 4 of zero for n codepoints, sometimes the extremes or random
   function automatic logic signed [FIELD_W-1:0] pick_bound(int n, bit for_length);
      int v;
      case ($urandom_range(0, 11))
         8: return {1'b1, 32'h0};
         9: return {1'b0, 32'hFFFF_FFFF};
         10: return any33();
         11: return for_length ? {1'b0, 32'hFFFF_FFFF} : 33'sd0;
         default: begin
            v = int'($urandom_range(0, 2 * n + 8)) - (n + 4);
            return FIELD_W'(v);
         end
      endcase
   endfunction

   function automatic int count_leads(ref logic [7:0] q[$]);
      int c;
      c = 0;
      foreach (q[i]) if (q[i][7:6] != 2'b10) c++;
      return c;
   endfunction

   task automatic build_text(ref logic [7:0] q[$], input int ncp, input bit junk);
      int kind;
      q.delete();
      for (int c = 0; c < ncp; c++) begin
         if (junk) begin
            q.push_back(8'($urandom()));
         end else begin
            kind = $urandom_range(1, 4);
            case (kind)
               1: q.push_back({1'b0, 7'($urandom())});
               2: q.push_back({3'b110, 5'($urandom())});
               3: q.push_back({4'b1110, 4'($urandom())});
               default: q.push_back({5'b11110, 3'($urandom())});
            endcase
            for (int k = 1; k < kind; k++) q.push_back({2'b10, 6'($urandom())});
         end
      end
   endtask

   task automatic send_item(input logic [7:0] d, input logic p, input logic f,
                            input logic l, input logic signed [FIELD_W-1:0] o,
                            input logic signed [FIELD_W-1:0] n);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_data_byte    <= d;
      req_byte_present <= p;
      req_first_byte   <= f;
      req_last_byte    <= l;
      req_start_offset <= o;
      req_take_length  <= n;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // broken strings drop the first mark at random and scatter extra last marks
   task automatic send_text(ref logic [7:0] q[$], input logic signed [FIELD_W-1:0] o,
                            input logic signed [FIELD_W-1:0] n, input bit broken);
      logic f, l;
      for (int i = 0; i < q.size(); i++) begin
         f = (i == 0);
         l = (i == q.size() - 1);
         if (broken) begin
            f = f && $urandom_range(0, 1);
            l = l || ($urandom_range(0, 5) == 0);
         end
         send_item(q[i], 1'b1, f, l, f ? o : any33(), f ? n : any33());
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      int n, target, ncp;
      logic signed [FIELD_W-1:0] o;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero-length strings with the largest length, then with the most negative offset and length
      send_item(8'h41, 1'b0, 1'b1, 1'b1, 33'sd1, {1'b0, 32'hFFFF_FFFF});
      send_item(8'hFF, 1'b0, 1'b1, 1'b1, {1'b1, 32'h0}, {1'b1, 32'h0});
      // one codepoint of each encoded size
      text = '{8'h61, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
      send_text(text, 33'sd2, 33'sd2, 1'b0);
      // offset zero starts before the first codepoint
      text = '{8'h78};
      send_text(text, 33'sd0, 33'sd2, 1'b0);
      // negative offset with a negative length
      text = '{8'h78, 8'h79};
      send_text(text, -33'sd1, {1'b1, 32'h0}, 1'b0);
      // zero length gives the empty string
      text = '{8'h78, 8'h79, 8'h7A};
      send_text(text, 33'sd2, 33'sd0, 1'b0);
      // stray continuation byte and an invalid byte
      text = '{8'h80, 8'hFF, 8'h41};
      send_text(text, 33'sd1, {1'b0, 32'hFFFF_FFFF}, 1'b0);
      text = '{8'h7F};
      send_text(text, {1'b0, 32'hFFFF_FFFF}, 33'sd1, 1'b0);
      // a last item with no first mark keeps adding to the previous string
      send_item(8'h7A, 1'b1, 1'b0, 1'b1, any33(), any33());
      send_item(8'hC0, 1'b1, 1'b1, 1'b0, -33'sd2, -33'sd1);
      send_item(8'hBF, 1'b1, 1'b0, 1'b1, any33(), any33());
      drain();

      // string of exactly the maximum size, then one byte too many
      build_text(text, 4200, 1'b0);
      while (text.size() > MAX_BYTES_DEF) void'(text.pop_back());
      send_text(text, 33'sd1, {1'b0, 32'hFFFF_FFFF}, 1'b0);
      send_item(8'h41, 1'b1, 1'b0, 1'b1, any33(), any33());
      drain();
      build_text(text, 4200, 1'b0);
      while (text.size() > MAX_BYTES_DEF + 2) void'(text.pop_back());
      n = count_leads(text);
      o = FIELD_W'($urandom_range(1, n));
      send_text(text, o, pick_bound(n, 1'b1), 1'b0);
      drain();

      target = sent + 950;
      while (sent < target) begin
         burst = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 19))
            0, 1: begin
               send_item(8'($urandom()), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 2) == 0, any33(), any33());
            end
            2: begin
               send_item(8'($urandom()), 1'b0, 1'b1, 1'b1, pick_bound(0, 1'b0),
                         pick_bound(0, 1'b1));
            end
            default: begin
               ncp = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
               build_text(text, ncp, $urandom_range(0, 9) == 0);
               n = count_leads(text);
               send_text(text, pick_bound(n, 1'b0), pick_bound(n, 1'b1),
                         $urandom_range(0, 17) == 0);
            end
         endcase
         if ($urandom_range(0, 39) == 0) drain();
      end
      burst = 1'b0;
      drain();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
